// File: src/exps_pkg.sv
// Shared types, constants and helpers for the exponential search engine.
// No dependencies; exps_seq and the top module import this package.
`default_nettype none

package exps_pkg;

    // Store geometry
    localparam int DEPTH  = 1024;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ELEM_W = 32;
    localparam int CNT_W  = ADDR_W + 1;

    // Reset value of the used-count register
    localparam logic [CNT_W-1:0] USED_COUNT_RST = CNT_W'(DEPTH);

    // Item function codes
    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE0,
        S_GALLOP,
        S_BIN,
        S_DONE
    } state_t;

    // Single-port request towards the element RAM
    typedef struct packed {
        logic              en;
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [ELEM_W-1:0] wdata;
    } mem_req_t;

    // Midpoint of an inclusive range, lo <= hi
    function automatic logic [ADDR_W-1:0] mid_of(input logic [ADDR_W-1:0] lo,
                                                 input logic [ADDR_W-1:0] hi);
        logic [ADDR_W:0] sum;
        begin
            sum = {1'b0, lo} + {1'b0, hi};
            return sum[ADDR_W:1];
        end
    endfunction

endpackage

`default_nettype wire

// File: src/exps_ram.sv
// Generic single-port synchronous RAM, registered read.
// Standalone; no package dependency.
`default_nettype none

module exps_ram #(
    parameter int ADDR_W = 10,
    parameter int DATA_W = 32
) (
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [DATA_W-1:0] wdata,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [(1 << ADDR_W)];

    // Write or read one entry per cycle
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

`default_nettype wire

// File: src/exps_seq.sv
// Search sequencer: store writes and the probe, gallop and binary phases over the element RAM,
// plus the result output register. Depends on exps_pkg.
`default_nettype none

module exps_seq
    import exps_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [CNT_W-1:0]  used_count,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              func,
    input  wire logic [ADDR_W-1:0] index,
    input  wire logic [ELEM_W-1:0] value,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   found,
    output logic      [ADDR_W-1:0] position,
    output mem_req_t               mem_req,
    input  wire logic [ELEM_W-1:0] mem_rdata
);

    state_t            state_reg, state_next;
    logic [ELEM_W-1:0] key_reg, key_next;
    logic [ADDR_W-1:0] lo_reg, lo_next;
    logic [ADDR_W-1:0] hi_reg, hi_next;
    logic [ADDR_W-1:0] mid_reg, mid_next;
    logic              hit_reg, hit_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic              out_valid_reg, out_valid_next;
    logic              found_reg, found_next;
    logic [ADDR_W-1:0] position_reg, position_next;

    logic [ADDR_W-1:0] last;
    logic              eq;
    logic              lt;
    logic [ADDR_W:0]   dbl;
    logic [ADDR_W-1:0] hnew;
    logic              gal_more;
    logic              slot_free;
    logic [ADDR_W-1:0] mid_calc;

    // Last usable index, with the count saturated to 1..DEPTH
    always_comb
    begin
        if (used_count == '0)
        begin
            last = '0;
        end
        else if (used_count > CNT_W'(DEPTH))
        begin
            last = ADDR_W'(DEPTH - 1);
        end
        else
        begin
            last = ADDR_W'(used_count - CNT_W'(1));
        end
    end

    // Compare the element just read against the key
    assign eq = (mem_rdata == key_reg);
    assign lt = ($signed(mem_rdata) < $signed(key_reg));

    // Doubled upper bound, clamped to the last index
    assign dbl      = {hi_reg, 1'b0};
    assign hnew     = (dbl > {1'b0, last}) ? last : dbl[ADDR_W-1:0];
    assign gal_more = (hnew < last);

    assign slot_free = !out_valid_reg || out_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && func == FUNC_SEARCH)
                begin
                    state_next = S_PROBE0;
                end
            end
            S_PROBE0:
            begin
                if (eq)
                begin
                    state_next = S_DONE;
                end
                else if (last > ADDR_W'(1))
                begin
                    state_next = S_GALLOP;
                end
                else
                begin
                    state_next = S_BIN;
                end
            end
            S_GALLOP:
            begin
                if (lt && gal_more)
                begin
                    state_next = S_GALLOP;
                end
                else
                begin
                    state_next = S_BIN;
                end
            end
            S_BIN:
            begin
                if (eq)
                begin
                    state_next = S_DONE;
                end
                else if (lt)
                begin
                    state_next = (mid_reg == hi_reg) ? S_DONE : S_BIN;
                end
                else
                begin
                    state_next = (mid_reg == lo_reg) ? S_DONE : S_BIN;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath, RAM requests and output register loads
    always_comb
    begin
        key_next       = key_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        hit_next       = hit_reg;
        pos_next       = pos_reg;
        found_next     = found_reg;
        position_next  = position_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        mid_calc       = '0;
        mem_req        = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    mem_req.en = 1'b1;
                    if (func == FUNC_WRITE)
                    begin
                        mem_req.we    = 1'b1;
                        mem_req.addr  = index;
                        mem_req.wdata = value;
                    end
                    else
                    begin
                        key_next = value;
                    end
                end
            end
            S_PROBE0:
            begin
                if (eq)
                begin
                    hit_next = 1'b1;
                    pos_next = '0;
                end
                else
                begin
                    hit_next = 1'b0;
                    pos_next = '0;
                    lo_next  = '0;
                    mem_req.en = 1'b1;
                    if (last > ADDR_W'(1))
                    begin
                        hi_next      = ADDR_W'(1);
                        mem_req.addr = ADDR_W'(1);
                    end
                    else
                    begin
                        hi_next      = (last == '0) ? '0 : ADDR_W'(1);
                        mid_calc     = mid_of('0, hi_next);
                        mid_next     = mid_calc;
                        mem_req.addr = mid_calc;
                    end
                end
            end
            S_GALLOP:
            begin
                mem_req.en = 1'b1;
                if (lt)
                begin
                    lo_next = hi_reg;
                    hi_next = hnew;
                    if (gal_more)
                    begin
                        mem_req.addr = hnew;
                    end
                    else
                    begin
                        mid_calc     = mid_of(hi_reg, hnew);
                        mid_next     = mid_calc;
                        mem_req.addr = mid_calc;
                    end
                end
                else
                begin
                    mid_calc     = mid_of(lo_reg, hi_reg);
                    mid_next     = mid_calc;
                    mem_req.addr = mid_calc;
                end
            end
            S_BIN:
            begin
                if (eq)
                begin
                    hit_next = 1'b1;
                    pos_next = mid_reg;
                end
                else if (lt)
                begin
                    if (mid_reg != hi_reg)
                    begin
                        lo_next      = mid_reg + ADDR_W'(1);
                        mid_calc     = mid_of(lo_next, hi_reg);
                        mid_next     = mid_calc;
                        mem_req.en   = 1'b1;
                        mem_req.addr = mid_calc;
                    end
                end
                else
                begin
                    if (mid_reg != lo_reg)
                    begin
                        hi_next      = mid_reg - ADDR_W'(1);
                        mid_calc     = mid_of(lo_reg, hi_next);
                        mid_next     = mid_calc;
                        mem_req.en   = 1'b1;
                        mem_req.addr = mid_calc;
                    end
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    found_next     = hit_reg;
                    position_next  = hit_reg ? pos_reg : '0;
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        hit_reg      <= hit_next;
        pos_reg      <= pos_next;
        found_reg    <= found_next;
        position_reg <= position_next;
    end

    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign position  = position_reg;

endmodule

`default_nettype wire

// File: src/exponential_search_engine.sv
// Exponential search engine top: configuration register, search sequencer and element RAM.
// Depends on exps_pkg, exps_seq and exps_ram.
// Operation: a write beat leaves the engine idle; a search reads index 0, then up to 10 galloping
// and up to 10 binary indices at one RAM read a cycle, and the engine takes no new beat until
// that search's result is loaded, later still while an earlier result waits on out_ready.
// Reset clears the sequencer and out_valid and sets used_count to 1024; the store is not cleared.
`default_nettype none

module exponential_search_engine
    import exps_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CNT_W-1:0]  used_count,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              func,
    input  wire logic [ADDR_W-1:0] index,
    input  wire logic [ELEM_W-1:0] value,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   found,
    output logic      [ADDR_W-1:0] position
);

    logic [CNT_W-1:0]  used_count_reg;
    mem_req_t          mem_req;
    logic [ELEM_W-1:0] mem_rdata;

    // Configuration register, written whenever a beat arrives
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_count_reg <= USED_COUNT_RST;
        end
        else if (cfg_valid)
        begin
            used_count_reg <= used_count;
        end
    end

    exps_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .used_count (used_count_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .index      (index),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .found      (found),
        .position   (position),
        .mem_req    (mem_req),
        .mem_rdata  (mem_rdata)
    );

    exps_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (ELEM_W)
    ) u_ram (
        .clk   (clk),
        .en    (mem_req.en),
        .we    (mem_req.we),
        .addr  (mem_req.addr),
        .wdata (mem_req.wdata),
        .rdata (mem_rdata)
    );

`ifndef SYNTH
    // A search beat makes the engine busy on the next cycle
    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && func == FUNC_SEARCH) |=> !in_ready)
        else $error("engine accepted a beat straight after a search");

    // A miss always reports position zero
    a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (position == '0))
        else $error("miss reported with non-zero position");

    // Store writes only happen while the engine is idle
    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_req.en && mem_req.we) |-> (in_ready && in_valid && func == FUNC_WRITE))
        else $error("store written outside a write beat");
`endif

endmodule

`default_nettype wire
